@@ src/stup_pkg.sv @@
// Shared types and character constants for the string-to-unsigned parser.
`default_nettype none

package stup_pkg;

  // Characters the parser recognises
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_9   = 8'h39;
  localparam logic [7:0] CH_UA  = 8'h41;
  localparam logic [7:0] CH_UF  = 8'h46;
  localparam logic [7:0] CH_UX  = 8'h58;
  localparam logic [7:0] CH_LA  = 8'h61;
  localparam logic [7:0] CH_LF  = 8'h66;
  localparam logic [7:0] CH_LX  = 8'h78;

  // Bases
  localparam logic [5:0] RADIX_AUTO = 6'd0;
  localparam logic [5:0] BASE_OCT   = 6'd8;
  localparam logic [5:0] BASE_DEC   = 6'd10;
  localparam logic [5:0] BASE_HEX   = 6'd16;

  // Digit code for a character that is no digit
  localparam logic [4:0] DIGIT_NONE = 5'd16;

  // Queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // One classified character
  typedef struct packed {
    logic       is_nul;
    logic       is_blank;
    logic       is_zero;
    logic       is_x;
    logic [4:0] digit;
  } char_class_t;

endpackage

`default_nettype wire

@@ src/stup_front.sv @@
// Front end: accepts characters and classifies them for the queue.
`default_nettype none

module stup_front (
  input  wire logic                 push,
  output logic                      full,
  input  wire logic [7:0]           char_in,
  input  wire logic                 q_full,
  output logic                      q_wr,
  output stup_pkg::char_class_t     q_item
);

  logic [4:0] digit;

  always_comb begin
    priority if (char_in >= stup_pkg::CH_0 && char_in <= stup_pkg::CH_9) begin
      digit = 5'(char_in - stup_pkg::CH_0);
    end else if (char_in >= stup_pkg::CH_LA && char_in <= stup_pkg::CH_LF) begin
      digit = 5'(char_in - stup_pkg::CH_LA + 8'd10);
    end else if (char_in >= stup_pkg::CH_UA && char_in <= stup_pkg::CH_UF) begin
      digit = 5'(char_in - stup_pkg::CH_UA + 8'd10);
    end else begin
      digit = stup_pkg::DIGIT_NONE;
    end
  end

  assign q_item.is_nul   = (char_in == stup_pkg::CH_NUL);
  assign q_item.is_blank = (char_in == stup_pkg::CH_SP) || (char_in == stup_pkg::CH_TAB);
  assign q_item.is_zero  = (char_in == stup_pkg::CH_0);
  assign q_item.is_x     = (char_in == stup_pkg::CH_LX) || (char_in == stup_pkg::CH_UX);
  assign q_item.digit    = digit;

  assign full = q_full;
  assign q_wr = push && !q_full;

endmodule

`default_nettype wire

@@ src/stup_queue.sv @@
// Short queue of classified characters between front and back.
`default_nettype none

module stup_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  wr,
  input  wire stup_pkg::char_class_t wr_item,
  output logic                       full,
  output logic                       valid,
  output stup_pkg::char_class_t      rd_item,
  input  wire logic                  rd
);

  stup_pkg::char_class_t slots [stup_pkg::QDEPTH];
  logic [stup_pkg::QPTR_W-1:0] wr_ptr;
  logic [stup_pkg::QPTR_W-1:0] rd_ptr;
  logic [stup_pkg::QCNT_W-1:0] count;

  assign full    = (count == stup_pkg::QCNT_W'(stup_pkg::QDEPTH));
  assign valid   = (count != '0);
  assign rd_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == stup_pkg::QPTR_W'(stup_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == stup_pkg::QPTR_W'(stup_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/stup_back.sv @@
// Back end: prefix and digit state machine, accumulator and result register.
`default_nettype none

module stup_back #(
  parameter int MAX_LEN = 255
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [5:0]            cfg_data,
  input  wire logic                  q_valid,
  input  wire stup_pkg::char_class_t q_item,
  output logic                       q_rd,
  output logic                       empty,
  input  wire logic                  pop,
  output logic [63:0]                value,
  output logic [7:0]                 end_offset
);

  localparam int POS_W = $clog2(MAX_LEN + 1);
  localparam int EXT_W = (POS_W > 8) ? POS_W : 8;

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_ZERO,
    PH_DIGITS,
    PH_STOPPED
  } phase_t;

  phase_t             phase;
  logic [5:0]         radix;
  logic [5:0]         active_base;
  logic [63:0]        accumulator;
  logic [POS_W-1:0]   position;
  logic [POS_W-1:0]   stop_position;
  logic               out_valid;

  logic               out_free;
  logic [5:0]         auto_base;
  logic [5:0]         mul_base;
  logic               digit_ok;
  logic [63:0]        product;
  logic [63:0]        accumulator_next;
  logic [POS_W-1:0]   position_next;
  logic [EXT_W-1:0]   end_ext;

  assign out_free = !out_valid || pop;
  assign q_rd     = q_valid && (!q_item.is_nul || out_free);
  assign empty    = !out_valid;

  // Base for the first character after the blanks
  assign auto_base = (radix == stup_pkg::RADIX_AUTO) ? stup_pkg::BASE_DEC : radix;
  assign mul_base  = (phase == PH_SKIP) ? auto_base : active_base;
  assign digit_ok  = (q_item.digit != stup_pkg::DIGIT_NONE) &&
                     ({1'b0, q_item.digit} < mul_base);

  assign product          = accumulator * 64'(mul_base);
  assign accumulator_next = product + 64'(q_item.digit[3:0]);
  assign position_next    = (position < POS_W'(MAX_LEN)) ? position + 1'b1 : position;

  assign end_ext = (phase == PH_STOPPED) ? EXT_W'(stop_position) : EXT_W'(position);

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= stup_pkg::RADIX_AUTO;
    end else if (cfg_we) begin
      radix <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SKIP;
      active_base   <= '0;
      accumulator   <= '0;
      position      <= '0;
      stop_position <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      if (q_rd) begin
        if (q_item.is_nul) begin
          // Deliver the result and clear for the next string
          out_valid     <= 1'b1;
          value         <= accumulator;
          end_offset    <= end_ext[7:0];
          phase         <= PH_SKIP;
          active_base   <= '0;
          accumulator   <= '0;
          position      <= '0;
          stop_position <= '0;
        end else begin
          unique case (phase)
            PH_SKIP: begin
              priority if (q_item.is_blank) begin
                position <= position_next;
              end else if (q_item.is_zero && radix == stup_pkg::RADIX_AUTO) begin
                active_base <= stup_pkg::BASE_OCT;
                position    <= position_next;
                phase       <= PH_ZERO;
              end else if (q_item.is_zero && radix == stup_pkg::BASE_HEX) begin
                active_base <= stup_pkg::BASE_HEX;
                position    <= position_next;
                phase       <= PH_ZERO;
              end else begin
                active_base <= auto_base;
                if (digit_ok) begin
                  accumulator <= accumulator_next;
                  position    <= position_next;
                  phase       <= PH_DIGITS;
                end else begin
                  stop_position <= position;
                  phase         <= PH_STOPPED;
                end
              end
            end
            PH_ZERO, PH_DIGITS: begin
              if (phase == PH_ZERO && q_item.is_x) begin
                active_base <= stup_pkg::BASE_HEX;
                position    <= position_next;
                phase       <= PH_DIGITS;
              end else if (digit_ok) begin
                accumulator <= accumulator_next;
                position    <= position_next;
                phase       <= PH_DIGITS;
              end else begin
                stop_position <= position;
                phase         <= PH_STOPPED;
              end
            end
            PH_STOPPED: begin
              // Drop characters until the terminator
            end
            default: begin
              phase <= PH_SKIP;
            end
          endcase
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_stop_not_past: assert property (@(posedge clk) disable iff (rst)
    stop_position <= position)
    else $error("stop position beyond position");

  a_pos_limit: assert property (@(posedge clk) disable iff (rst)
    position <= POS_W'(MAX_LEN))
    else $error("position beyond limit");

  a_prefix_clear: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SKIP || phase == PH_ZERO) |-> accumulator == '0)
    else $error("accumulator non-zero before digits");

  a_result_only_on_nul: assert property (@(posedge clk) disable iff (rst)
    (!out_valid && !(q_rd && q_item.is_nul)) |=> !out_valid)
    else $error("result without terminator");
`endif

endmodule

`default_nettype wire

@@ src/string_to_unsigned_parser_top.sv @@
// Top level of the streaming string-to-unsigned parser.
`default_nettype none

// Streaming string-to-unsigned converter. Characters enter one per transfer
// on the push/full side; a NUL ends the string and yields one result
// (value and end_offset) on the empty/pop side, after which the parser is
// ready for the next string. Leading spaces and tabs are skipped; radix 0
// picks the base from the prefix (0x/0X hex, 0 octal, else decimal) and
// radix 16 skips an optional 0x. The value wraps modulo 2^64, the consumed
// count saturates at MAX_LEN and end_offset carries its low 8 bits.
// Throughput is one character per clock unless a NUL waits for an unpopped
// result: the back end folds each digit into the accumulator with a single
// 64 by 6 bit multiply-add, and that loop sets the figure. The queue registers
// each character before the back end takes it; a result shows on the ports in
// the cycle after its NUL leaves the queue. The radix register is sampled at
// a string's first non-blank character. No clearing pass follows reset.
module string_to_unsigned_parser_top #(
  parameter int MAX_LEN = 255
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration: radix register
  input  wire logic        cfg_we,
  input  wire logic [5:0]  cfg_data,
  // Character input
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  char_in,
  // Result output
  output logic             empty,
  input  wire logic        pop,
  output logic [63:0]      value,
  output logic [7:0]       end_offset
);

  // Front to queue
  logic                  fq_wr;
  stup_pkg::char_class_t fq_item;
  logic                  q_full;

  // Queue to back
  logic                  q_valid;
  stup_pkg::char_class_t q_item;
  logic                  q_rd;

  // Classify each character as it is transferred in
  stup_front u_front (
    .push    (push),
    .full    (full),
    .char_in (char_in),
    .q_full  (q_full),
    .q_wr    (fq_wr),
    .q_item  (fq_item)
  );

  // Hold classified characters between front and back; input stalls once the queue is full
  stup_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (fq_wr),
    .wr_item (fq_item),
    .full    (q_full),
    .valid   (q_valid),
    .rd_item (q_item),
    .rd      (q_rd)
  );

  // Run the prefix and digit state machine and hold the result
  stup_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_rd       (q_rd),
    .empty      (empty),
    .pop        (pop),
    .value      (value),
    .end_offset (end_offset)
  );

endmodule

`default_nettype wire

@@ tb/tb_string_to_unsigned_parser_top.sv @@
// Self-checking testbench for the streaming string-to-unsigned parser.
`timescale 1ns / 1ps

module tb_string_to_unsigned_parser_top;

  localparam int CLK_PERIOD     = 4;
  localparam int RESET_CYCLES   = 4;
  localparam int STR_MAX_LEN    = 255;
  // Characters per random phase; twelve phases give roughly 2000 transfers
  localparam int PHASE_CHARS    = 170;
  localparam int NUM_PHASES     = 12;
  // A character passes the queue before the back end takes it and a result is
  // registered before it shows; allow a good margin before touching the radix register
  localparam int SETTLE_CYCLES  = 8;
  localparam int MAX_GAP        = 16;
  localparam int MAX_REPORTS    = 10;
  localparam int TIMEOUT_CYCLES = 500_000;

  // Radix settings walked through by the random phases: the common bases, the
  // degenerate base one, the top of the nominal range and values beyond it,
  // including all ones. The last phase draws a radix at random.
  localparam logic [5:0] RADIX_PLAN [11] = '{
    stup_pkg::BASE_HEX, stup_pkg::BASE_DEC, stup_pkg::BASE_OCT, 6'd1, 6'd2, 6'd36,
    6'd63, 6'd37, stup_pkg::RADIX_AUTO, stup_pkg::BASE_HEX, 6'd5
  };

  // Short hand-written strings, all parsed with automatic base detection:
  //   tab and space, then "0x1f"       - blanks, lower-case hex prefix
  //   "017"                            - octal from a leading zero
  //   "0X"                             - prefix with no digit after it
  //   (empty)                          - NUL on its own
  //   "9", 0xFF, "5"                   - stop on a non-digit, ignore the rest
  //   two spaces                       - blank string
  localparam logic [7:0] DIRECTED_CHARS [22] = '{
    stup_pkg::CH_TAB, stup_pkg::CH_SP, stup_pkg::CH_0, stup_pkg::CH_LX,
    stup_pkg::CH_0 + 8'd1, stup_pkg::CH_LF, stup_pkg::CH_NUL,
    stup_pkg::CH_0, stup_pkg::CH_0 + 8'd1, stup_pkg::CH_0 + 8'd7, stup_pkg::CH_NUL,
    stup_pkg::CH_0, stup_pkg::CH_UX, stup_pkg::CH_NUL,
    stup_pkg::CH_NUL,
    stup_pkg::CH_9, 8'hFF, stup_pkg::CH_0 + 8'd5, stup_pkg::CH_NUL,
    stup_pkg::CH_SP, stup_pkg::CH_SP, stup_pkg::CH_NUL
  };

  typedef enum logic [1:0] {
    SCAN_BLANKS,
    SCAN_LEAD_ZERO,
    SCAN_DIGITS,
    SCAN_STOPPED
  } scan_phase_t;

  typedef struct packed {
    logic [63:0] num;
    logic [7:0]  offset;
  } parsed_number_t;

  // Tracks the parser's state from every accepted character and holds the
  // numbers it should produce, oldest first.
  class number_scoreboard;
    logic [5:0]     radix;
    scan_phase_t    scan;
    logic [5:0]     base;
    logic [63:0]    acc;
    int unsigned    consumed;
    int unsigned    stopped_at;
    parsed_number_t expected_numbers[$];
    int unsigned    failures;
    int unsigned    reported;

    function new();
      radix     = stup_pkg::RADIX_AUTO;
      failures  = 0;
      reported  = 0;
      restart();
    endfunction

    function void restart();
      scan       = SCAN_BLANKS;
      base       = '0;
      acc        = '0;
      consumed   = 0;
      stopped_at = 0;
    endfunction

    function void set_radix(logic [5:0] r);
      radix = r;
    endfunction

    function int pending();
      return expected_numbers.size();
    endfunction

    function void count_char();
      if (consumed < STR_MAX_LEN) begin
        consumed++;
      end
    endfunction

    // Weight of a character as a digit; DIGIT_NONE where it is no digit
    function int digit_weight(logic [7:0] c);
      if (c >= stup_pkg::CH_0 && c <= stup_pkg::CH_9) begin
        return int'(c - stup_pkg::CH_0);
      end
      if (c >= stup_pkg::CH_LA && c <= stup_pkg::CH_LF) begin
        return int'(c - stup_pkg::CH_LA) + 10;
      end
      if (c >= stup_pkg::CH_UA && c <= stup_pkg::CH_UF) begin
        return int'(c - stup_pkg::CH_UA) + 10;
      end
      return int'(stup_pkg::DIGIT_NONE);
    endfunction

    function void fold_digit(logic [7:0] c);
      int d;
      d = digit_weight(c);
      if (d >= int'(stup_pkg::DIGIT_NONE) || d >= int'(base)) begin
        stopped_at = consumed;
        scan       = SCAN_STOPPED;
      end else begin
        acc  = acc * 64'(base) + 64'(d);
        count_char();
        scan = SCAN_DIGITS;
      end
    endfunction

    function void note_char(logic [7:0] c);
      parsed_number_t n;
      if (c == stup_pkg::CH_NUL) begin
        n.num    = acc;
        n.offset = 8'((scan == SCAN_STOPPED) ? stopped_at : consumed);
        expected_numbers.push_back(n);
        restart();
        return;
      end
      case (scan)
        SCAN_BLANKS: begin
          if (c == stup_pkg::CH_SP || c == stup_pkg::CH_TAB) begin
            count_char();
          end else if (c == stup_pkg::CH_0 &&
                       (radix == stup_pkg::RADIX_AUTO || radix == stup_pkg::BASE_HEX)) begin
            base = (radix == stup_pkg::RADIX_AUTO) ? stup_pkg::BASE_OCT : stup_pkg::BASE_HEX;
            count_char();
            scan = SCAN_LEAD_ZERO;
          end else begin
            base = (radix == stup_pkg::RADIX_AUTO) ? stup_pkg::BASE_DEC : radix;
            fold_digit(c);
          end
        end
        SCAN_LEAD_ZERO: begin
          if (c == stup_pkg::CH_LX || c == stup_pkg::CH_UX) begin
            base = stup_pkg::BASE_HEX;
            count_char();
            scan = SCAN_DIGITS;
          end else begin
            fold_digit(c);
          end
        end
        SCAN_DIGITS: begin
          fold_digit(c);
        end
        default: begin
        end
      endcase
    endfunction

    function void note_mismatch(string what, logic [63:0] want, logic [63:0] got);
      failures++;
      if (reported < MAX_REPORTS) begin
        reported++;
        $display("[%0t] %s mismatch: expected %0h, got %0h", $realtime, what, want, got);
      end
    endfunction

    function void check_number(logic [63:0] got_num, logic [7:0] got_off);
      parsed_number_t want;
      if (expected_numbers.size() == 0) begin
        failures++;
        if (reported < MAX_REPORTS) begin
          reported++;
          $display("[%0t] unexpected result: value %0h end_offset %0d", $realtime,
                   got_num, got_off);
        end
        return;
      end
      want = expected_numbers.pop_front();
      if (got_num !== want.num) begin
        note_mismatch("value", want.num, got_num);
      end
      if (got_off !== want.offset) begin
        note_mismatch("end_offset", 64'(want.offset), 64'(got_off));
      end
    endfunction
  endclass

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        cfg_we   = 1'b0;
  logic [5:0]  cfg_data = '0;
  logic        push     = 1'b0;
  logic        full;
  logic [7:0]  char_in  = '0;
  logic        empty;
  logic        pop      = 1'b0;
  logic [63:0] value;
  logic [7:0]  end_offset;

  number_scoreboard board = new();

  // Characters waiting to be sent; a string may straddle a phase boundary, so
  // the radix can change between its first character and its NUL
  logic [7:0] stream_q[$];
  logic [5:0] cur_radix  = stup_pkg::RADIX_AUTO;
  bit         feed_calm  = 1'b0;
  bit         drain_calm = 1'b0;

  string_to_unsigned_parser_top #(
    .MAX_LEN(STR_MAX_LEN)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .char_in   (char_in),
    .empty     (empty),
    .pop       (pop),
    .value     (value),
    .end_offset(end_offset)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Draw a random idle gap for each item, but now and then switch into (or out
  // of) a calm stretch in which the side runs flat out
  function automatic int draw_gap(inout bit calm);
    if ($urandom_range(0, 39) == 0) begin
      calm = !calm;
    end
    return calm ? 0 : int'($urandom_range(0, MAX_GAP));
  endfunction

  function automatic logic [7:0] digit_char(int d);
    if (d < 10) begin
      return stup_pkg::CH_0 + 8'(d);
    end
    return ($urandom_range(0, 1) ? stup_pkg::CH_LA : stup_pkg::CH_UA) + 8'(d - 10);
  endfunction

  function automatic logic [7:0] blank_char();
    return $urandom_range(0, 1) ? stup_pkg::CH_SP : stup_pkg::CH_TAB;
  endfunction

  // Append one string, NUL included. Most are well formed (blanks, optional
  // prefix, digits mostly valid for the base, sometimes trailing junk); the
  // rest are raw noise or strings near or past the length that saturates the count.
  function automatic void queue_string();
    int kind;
    int n;
    int lim;
    int prefix;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      n = $urandom_range(0, 8);
      repeat (n) stream_q.push_back(8'($urandom_range(1, 255)));
    end else if (kind < 11) begin
      n = $urandom_range(STR_MAX_LEN - 5, STR_MAX_LEN + 45);
      if ($urandom_range(0, 1)) begin
        repeat (n) stream_q.push_back(blank_char());
      end else begin
        repeat (n) stream_q.push_back(digit_char($urandom_range(0, 15)));
      end
    end else begin
      n = $urandom_range(0, 3);
      repeat (n) stream_q.push_back(blank_char());
      prefix = $urandom_range(0, 5);
      if (prefix <= 2) begin
        stream_q.push_back(stup_pkg::CH_0);
      end
      if (prefix == 1) begin
        stream_q.push_back(stup_pkg::CH_LX);
      end else if (prefix == 2) begin
        stream_q.push_back(stup_pkg::CH_UX);
      end
      // Pick the digit range the parser is likely to accept
      if (prefix == 1 || prefix == 2) begin
        lim = 16;
      end else if (cur_radix == stup_pkg::RADIX_AUTO) begin
        lim = (prefix == 0) ? 8 : 10;
      end else if (cur_radix > stup_pkg::BASE_HEX) begin
        lim = 16;
      end else begin
        lim = int'(cur_radix);
      end
      n = $urandom_range(0, 20);
      repeat (n) begin
        if ($urandom_range(0, 99) < 85) begin
          stream_q.push_back(digit_char($urandom_range(0, lim - 1)));
        end else begin
          stream_q.push_back(digit_char($urandom_range(0, 15)));
        end
      end
      if ($urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 3);
        repeat (n) stream_q.push_back(8'($urandom_range(1, 255)));
      end
    end
    stream_q.push_back(stup_pkg::CH_NUL);
  endfunction

  // Transfer one character. Push is left high after the transfer so that a
  // back-to-back character needs no second assignment in the same step.
  task automatic feed(input logic [7:0] c);
    int gap;
    gap = draw_gap(feed_calm);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push    <= 1'b1;
    char_in <= c;
    @(posedge clk);
    while (full) @(posedge clk);
    board.note_char(c);
  endtask

  // Drop push, wait for every pending result, then let the back end finish
  // any characters still in flight
  task automatic settle();
    push <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_radix(input logic [5:0] r);
    cfg_we   <= 1'b1;
    cfg_data <= r;
    @(posedge clk);
    cfg_we   <= 1'b0;
    board.set_radix(r);
    cur_radix = r;
  endtask

  // Result side: hold pop low for a random stretch, then take the next result
  // and check it against the oldest expected number
  initial begin
    int gap;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      gap = draw_gap(drain_calm);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      board.check_number(value, end_offset);
    end
  end

  // Stimulus: reset, the directed strings under automatic detection, then
  // random phases, each under its own radix
  initial begin
    int sent;
    logic [5:0] r;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    write_radix(stup_pkg::RADIX_AUTO);
    foreach (DIRECTED_CHARS[i]) begin
      feed(DIRECTED_CHARS[i]);
    end
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      r = (p < $size(RADIX_PLAN)) ? RADIX_PLAN[p] : 6'($urandom_range(0, 63));
      write_radix(r);
      sent = 0;
      // Stop at the character budget even mid-string; the rest of that string
      // goes out under the next radix
      while (sent < PHASE_CHARS) begin
        if (stream_q.size() == 0) begin
          queue_string();
        end
        feed(stream_q.pop_front());
        sent++;
      end
    end
    // Finish the last string so that it yields its number
    while (stream_q.size() != 0) begin
      feed(stream_q.pop_front());
    end
    settle();
    if (board.failures == 0 && board.pending() == 0) begin
      $display("** string_to_unsigned_parser_top: PASSED **");
    end else begin
      $display("** string_to_unsigned_parser_top: FAILED **");
    end
    $finish;
  end

  // Guard against a hang on either handshake
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("** string_to_unsigned_parser_top: FAILED **");
    $finish;
  end

endmodule
